>>> rtl/core/ssb_pkg.sv
`timescale 1ns / 1ps
// ssb_pkg: shared types and constants of the sparse set bucket
// operation and status codes, sizes, controller/datapath command and status structs
// no dependencies

package ssb_pkg;

  // sizes follow the fixed widths of the id and count fields
  localparam int CAPACITY = 256;
  localparam int ID_COUNT = 256;
  localparam int FUNC_W   = 3;
  localparam int ID_W     = $clog2(ID_COUNT);
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int STAT_W   = 3;

  // back index value of an id that holds no slot
  localparam logic [LEN_W-1:0] NONE_INDEX = LEN_W'(CAPACITY);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT   = 3'd0,
    FN_POP      = 3'd1,
    FN_REMOVE   = 3'd2,
    FN_CONTAINS = 3'd3,
    FN_SHRINK   = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_EMPTY      = 3'd2,
    ST_NOT_MEMBER = 3'd3,
    ST_BAD_LENGTH = 3'd4
  } status_t;

  typedef struct packed {
    logic accept;
    logic lookup;
    logic commit;
    logic fixup;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic rm_hit;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/core/ssb_in_if.sv
`timescale 1ns / 1ps
// ssb_in_if: request channel of the sparse set bucket
// valid/ready handshake with operation, id and target length; uses ssb_pkg

interface ssb_in_if
  import ssb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   item_id;
  logic [LEN_W-1:0]  new_length;

  modport source (output valid, func, item_id, new_length, input ready);
  modport sink (input valid, func, item_id, new_length, output ready);
endinterface

>>> rtl/core/ssb_out_if.sv
`timescale 1ns / 1ps
// ssb_out_if: response channel of the sparse set bucket
// valid/ready handshake with popped id, found flag, count and status; uses ssb_pkg

interface ssb_out_if
  import ssb_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   popped_id;
  logic              found;
  logic [LEN_W-1:0]  count;
  logic [STAT_W-1:0] status;

  modport source (output valid, popped_id, found, count, status, input ready);
  modport sink (input valid, popped_id, found, count, status, output ready);
endinterface

>>> rtl/core/ssb_ram.sv
`timescale 1ns / 1ps
// ssb_ram: generic simple dual port ram, one write and one registered read port
// no dependencies

module ssb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/ssb_ctrl.sv
`timescale 1ns / 1ps
// ssb_ctrl: sequencing state machine of the sparse set bucket
// issues phase commands to ssb_datapath; uses ssb_pkg

module ssb_ctrl
  import ssb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_CHECK,
    S_FIXUP,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign cmd.accept  = in_ready && in_valid;
  assign cmd.lookup  = (state_r == S_LOOKUP);
  assign cmd.commit  = (state_r == S_CHECK);
  assign cmd.fixup   = (state_r == S_FIXUP);
  assign cmd.respond = (state_r == S_RESP) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_LOOKUP;
      S_LOOKUP: state_nxt = S_CHECK;
      S_CHECK:  state_nxt = sts.rm_hit ? S_FIXUP : S_RESP;
      S_FIXUP:  state_nxt = S_RESP;
      S_RESP:   if (sts.out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/ssb_datapath.sv
`timescale 1ns / 1ps
// ssb_datapath: dense store, back index, length and response register
// driven by ssb_ctrl commands; uses ssb_pkg and ssb_ram

module ssb_datapath
  import ssb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [ID_W-1:0]   in_item_id,
  input  logic [LEN_W-1:0]  in_new_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ID_W-1:0]   out_popped_id,
  output logic              out_found,
  output logic [LEN_W-1:0]  out_count,
  output logic [STAT_W-1:0] out_status
);

  func_t             func_r;
  logic [ID_W-1:0]   id_r;
  logic [LEN_W-1:0]  nlen_r;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  len_dec;
  logic [LEN_W-1:0]  slot_r;
  logic [LEN_W-1:0]  slot_lk;
  logic [ID_W-1:0]   last_r;
  logic [ID_COUNT-1:0] bi_vld_r;
  logic              bi_vld_q_r;
  logic              member;
  logic              rm_hit;

  logic [ID_W-1:0]   popped_r, popped_nxt;
  logic              found_r, found_nxt;
  status_t           status_r, status_nxt;

  logic              out_valid_r;
  logic [ID_W-1:0]   out_popped_r;
  logic              out_found_r;
  logic [LEN_W-1:0]  out_count_r;
  logic [STAT_W-1:0] out_status_r;

  logic              ds_we;
  logic [SLOT_W-1:0] ds_waddr, ds_raddr;
  logic [ID_W-1:0]   ds_wdata, ds_rdata;
  logic              bi_we;
  logic [ID_W-1:0]   bi_waddr, bi_raddr;
  logic [LEN_W-1:0]  bi_wdata, bi_rdata;

  ssb_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_dense (
    .clk   (clk),
    .we    (ds_we),
    .waddr (ds_waddr),
    .wdata (ds_wdata),
    .raddr (ds_raddr),
    .rdata (ds_rdata)
  );

  ssb_ram #(.WIDTH(LEN_W), .DEPTH(ID_COUNT)) u_back (
    .clk   (clk),
    .we    (bi_we),
    .waddr (bi_waddr),
    .wdata (bi_wdata),
    .raddr (bi_raddr),
    .rdata (bi_rdata)
  );

  assign len_dec  = len_r - LEN_W'(1);
  // never-written back index entries read as none
  assign slot_lk  = bi_vld_q_r ? bi_rdata : NONE_INDEX;
  assign bi_raddr = in_item_id;
  // first read: last entry, second read: the slot named by the back index
  assign ds_raddr = cmd.accept ? len_dec[SLOT_W-1:0] : slot_lk[SLOT_W-1:0];
  // slot below length implies slot below capacity
  assign member   = (slot_r < len_r) && (ds_rdata == id_r);

  assign sts.rm_hit   = rm_hit;
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    ds_we      = 1'b0;
    ds_waddr   = len_r[SLOT_W-1:0];
    ds_wdata   = id_r;
    bi_we      = 1'b0;
    bi_waddr   = id_r;
    bi_wdata   = len_r;
    len_nxt    = len_r;
    popped_nxt = popped_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    rm_hit     = 1'b0;
    if (cmd.commit) begin
      popped_nxt = '0;
      found_nxt  = 1'b0;
      status_nxt = ST_OK;
      unique case (func_r)
        FN_INSERT: begin
          if (len_r == LEN_W'(CAPACITY)) begin
            status_nxt = ST_FULL;
          end else begin
            ds_we   = 1'b1;
            bi_we   = 1'b1;
            len_nxt = len_r + LEN_W'(1);
          end
        end
        FN_POP: begin
          if (len_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            popped_nxt = last_r;
            bi_we      = 1'b1;
            bi_waddr   = last_r;
            bi_wdata   = NONE_INDEX;
            len_nxt    = len_dec;
          end
        end
        FN_REMOVE: begin
          if (!member) begin
            status_nxt = ST_NOT_MEMBER;
          end else begin
            // last entry moves into the freed slot
            bi_we    = 1'b1;
            bi_waddr = last_r;
            bi_wdata = slot_r;
            ds_we    = 1'b1;
            ds_waddr = slot_r[SLOT_W-1:0];
            ds_wdata = last_r;
            len_nxt  = len_dec;
            rm_hit   = 1'b1;
          end
        end
        FN_CONTAINS: found_nxt = member;
        FN_SHRINK: begin
          if (nlen_r > len_r) begin
            status_nxt = ST_BAD_LENGTH;
          end else begin
            len_nxt = nlen_r;
          end
        end
        default: ;
      endcase
    end else if (cmd.fixup) begin
      // removed id loses its slot after the move, also when it was the last one
      bi_we    = 1'b1;
      bi_waddr = id_r;
      bi_wdata = NONE_INDEX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      bi_vld_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      if (bi_we) begin
        bi_vld_r[bi_waddr] <= 1'b1;
      end
      if (cmd.respond) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r     <= func_t'(in_func);
      id_r       <= in_item_id;
      nlen_r     <= in_new_length;
      bi_vld_q_r <= bi_vld_r[in_item_id];
    end
    if (cmd.lookup) begin
      slot_r <= slot_lk;
      last_r <= ds_rdata;
    end
    popped_r <= popped_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    if (cmd.respond) begin
      out_popped_r <= popped_r;
      out_found_r  <= found_r;
      out_count_r  <= len_r;
      out_status_r <= status_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_popped_id = out_popped_r;
  assign out_found     = out_found_r;
  assign out_count     = out_count_r;
  assign out_status    = out_status_r;

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(CAPACITY))
    else $error("length above capacity");

  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && func_r == FN_INSERT && len_r != LEN_W'(CAPACITY)
    |=> len_r == LEN_W'($past(len_r) + LEN_W'(1)))
    else $error("insert did not grow length");

  a_fixup_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fixup |-> $past(cmd.commit) && $past(rm_hit))
    else $error("back index fixup without a remove hit");

  a_respond_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.respond |-> !out_valid_r || out_ready)
    else $error("response register overwritten");

endmodule

>>> rtl/core/sparse_set_bucket.sv
`timescale 1ns / 1ps
// sparse_set_bucket: top level of the sparse set bucket
// joins ssb_ctrl and ssb_datapath; uses ssb_pkg, ssb_in_if and ssb_out_if
//
// usage
//   in_if carries one operation per transaction: insert, pop, remove, contains
//   or shrink, with item_id and new_length. out_if returns exactly one
//   transaction per request, in order: popped id, found flag, count after the
//   operation and a status code (ok, full, empty, not member, bad length).
//   failed operations leave the set unchanged.
//   a request steps through S_LOOKUP, S_CHECK and S_RESP, with S_FIXUP
//   before S_RESP for a remove that hits: the dependent back index -> dense
//   store read chain through the two registered-read memories and the final
//   back index write. a new request is taken once the last result is loaded.
//   the response sits in an output register, so the next request is accepted
//   while a result waits; a stalled receiver holds the block once a second
//   result is ready to be loaded.
//   reset (synchronous, active low) empties the set at once: per-id valid
//   flags mark every back index entry as none, no clearing pass is needed.

module sparse_set_bucket
  import ssb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ssb_in_if.sink    in_if,
  ssb_out_if.source out_if
);

  cmd_t cmd;
  sts_t sts;

  ssb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssb_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_func       (in_if.func),
    .in_item_id    (in_if.item_id),
    .in_new_length (in_if.new_length),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_popped_id (out_if.popped_id),
    .out_found     (out_if.found),
    .out_count     (out_if.count),
    .out_status    (out_if.status)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench of the sparse set bucket
// drives ssb_in_if, checks every ssb_out_if transaction against its own set model; uses ssb_pkg

module tb_top;
  import ssb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [ID_W-1:0]   popped_id;
    logic              found;
    logic [LEN_W-1:0]  count;
    logic [STAT_W-1:0] status;
  } set_result_t;

  logic clk;
  logic rst_n;

  ssb_in_if  in_if ();
  ssb_out_if out_if ();

  sparse_set_bucket dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // set model: slot array, per-id slot and length
  logic [ID_W-1:0]  set_slots [CAPACITY];
  logic [LEN_W-1:0] slot_of [ID_COUNT];
  logic [LEN_W-1:0] set_len;

  set_result_t expected_q [$];
  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic logic holds_id(input logic [ID_W-1:0] id);
    logic [LEN_W-1:0] slot;
    slot = slot_of[id];
    return (slot < set_len) && (set_slots[slot[SLOT_W-1:0]] == id);
  endfunction

  // applies one operation to the set model and returns the result it gives
  function automatic set_result_t apply_set_op(input logic [FUNC_W-1:0] f,
                                               input logic [ID_W-1:0] id,
                                               input logic [LEN_W-1:0] nl);
    set_result_t      res;
    logic [LEN_W-1:0] slot;
    logic [ID_W-1:0]  last;
    res = '0;
    res.status = ST_OK;
    case (f)
      FN_INSERT: begin
        if (set_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          slot_of[id] = set_len;
          set_slots[set_len[SLOT_W-1:0]] = id;
          set_len = set_len + 1'b1;
        end
      end
      FN_POP: begin
        if (set_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          last = set_slots[SLOT_W'(set_len - 1'b1)];
          res.popped_id = last;
          set_len = set_len - 1'b1;
          slot_of[last] = NONE_INDEX;
        end
      end
      FN_REMOVE: begin
        if (!holds_id(id)) begin
          res.status = ST_NOT_MEMBER;
        end else begin
          // last entry moves into the freed slot
          slot = slot_of[id];
          last = set_slots[SLOT_W'(set_len - 1'b1)];
          slot_of[last] = slot;
          set_slots[slot[SLOT_W-1:0]] = last;
          set_len = set_len - 1'b1;
          slot_of[id] = NONE_INDEX;
        end
      end
      FN_CONTAINS: begin
        res.found = holds_id(id);
      end
      FN_SHRINK: begin
        if (nl > set_len) res.status = ST_BAD_LENGTH;
        else set_len = nl;
      end
      default: begin
      end
    endcase
    res.count = set_len;
    return res;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                         input logic [LEN_W-1:0] nl);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= f;
    in_if.item_id    <= id;
    in_if.new_length <= nl;
    do @(posedge clk); while (!in_if.ready);
    expected_q.push_back(apply_set_op(f, id, nl));
    @(negedge clk);
  endtask

  // half the time an id that sits in the slot array, else mostly from a narrow range
  function automatic logic [ID_W-1:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5 && set_len > 0) return set_slots[SLOT_W'($urandom_range(0, set_len - 1))];
    if (r < 8) return ID_W'($urandom_range(0, 15));
    return ID_W'($urandom_range(0, ID_COUNT - 1));
  endfunction

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_op(FN_POP, 8'd0, 9'd0);
    send_op(FN_REMOVE, 8'd7, 9'd0);
    send_op(FN_CONTAINS, 8'd0, 9'd0);
    send_op(FN_SHRINK, 8'd0, 9'd0);
    send_op(FN_SHRINK, 8'd0, 9'd1);
    send_op(FN_INSERT, 8'd0, 9'd511);
    send_op(FN_INSERT, 8'd255, 9'd0);
    // second insert of a member appends it again
    send_op(FN_INSERT, 8'd0, 9'd0);
    send_op(FN_CONTAINS, 8'd0, 9'd0);
    send_op(FN_CONTAINS, 8'd255, 9'd256);
    send_op(FN_REMOVE, 8'd0, 9'd0);
    // stale copy in slot 0 is no longer a member
    send_op(FN_CONTAINS, 8'd0, 9'd0);
    send_op(FN_REMOVE, 8'd0, 9'd0);
    send_op(FN_REMOVE, 8'd128, 9'd0);
    send_op(FN_SHRINK, 8'd0, 9'd256);
    send_op(3'd5, 8'd255, 9'd511);
    send_op(3'd6, 8'd1, 9'd0);
    send_op(3'd7, 8'd2, 9'd3);
    send_op(FN_POP, 8'd255, 9'd0);
    send_op(FN_POP, 8'd0, 9'd0);
    send_op(FN_POP, 8'd0, 9'd0);
    send_op(FN_INSERT, 8'd170, 9'd0);
    send_op(FN_INSERT, 8'd85, 9'd0);
    send_op(FN_SHRINK, 8'd0, 9'd0);
    send_op(FN_CONTAINS, 8'd170, 9'd0);
  endtask

  task automatic test_fill();
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    while (set_len < CAPACITY) send_op(FN_INSERT, ID_W'($urandom_range(0, ID_COUNT - 1)), 9'd0);
    repeat (3) send_op(FN_INSERT, ID_W'($urandom_range(0, ID_COUNT - 1)),
                       LEN_W'($urandom_range(0, 511)));
    send_op(FN_CONTAINS, set_slots[SLOT_W'(CAPACITY - 1)], 9'd0);
    send_op(FN_SHRINK, 8'd0, 9'd256);
    send_op(FN_REMOVE, set_slots[SLOT_W'(CAPACITY - 1)], 9'd0);
    send_op(FN_SHRINK, 8'd0, 9'd256);
    send_op(FN_INSERT, 8'd255, 9'd0);
    send_op(FN_POP, 8'd0, 9'd0);
    send_op(FN_REMOVE, set_slots[SLOT_W'(0)], 9'd0);
    send_op(FN_SHRINK, 8'd0, 9'd0);
  endtask

  task automatic test_random(input int n_ops, input int grow_pct, input int idle_pct,
                             input int stall_pct);
    int               pick;
    int               drop;
    int               r;
    logic [FUNC_W-1:0] f;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  nl;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_ops; i++) begin
      pick = $urandom_range(0, 99);
      id   = pick_id();
      nl   = LEN_W'($urandom_range(0, 511));
      if (pick < grow_pct) begin
        f = FN_INSERT;
      end else if (pick < grow_pct + 12) begin
        f = FN_POP;
      end else if (pick < grow_pct + 30) begin
        f = FN_REMOVE;
      end else if (pick < grow_pct + 48) begin
        f = FN_CONTAINS;
      end else if (pick < 97) begin
        f    = FN_SHRINK;
        r    = $urandom_range(0, 9);
        drop = $urandom_range(0, 8);
        if (r == 0) nl = LEN_W'(set_len + $urandom_range(1, 511 - set_len));
        else if (r == 1) nl = LEN_W'($urandom_range(0, set_len));
        else nl = (set_len > drop) ? LEN_W'(set_len - drop) : '0;
      end else begin
        f = FUNC_W'($urandom_range(5, 7));
      end
      send_op(f, id, nl);
    end
  endtask

  // result receiver and checker
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    set_result_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with no request pending");
        error_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_if.popped_id !== exp_res.popped_id) begin
          $error("popped_id mismatch: expected %0d actual %0d", exp_res.popped_id,
                 out_if.popped_id);
          error_count++;
        end
        if (out_if.found !== exp_res.found) begin
          $error("found mismatch: expected %0d actual %0d", exp_res.found, out_if.found);
          error_count++;
        end
        if (out_if.count !== exp_res.count) begin
          $error("count mismatch: expected %0d actual %0d", exp_res.count, out_if.count);
          error_count++;
        end
        if (out_if.status !== exp_res.status) begin
          $error("status mismatch: expected %0d actual %0d", exp_res.status,
                 out_if.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    error_count      = 0;
    cycle_count      = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = '0;
    in_if.item_id    = '0;
    in_if.new_length = '0;
    out_if.ready     = 1'b0;
    set_len          = '0;
    for (int i = 0; i < ID_COUNT; i++) slot_of[ID_W'(i)] = NONE_INDEX;
    for (int i = 0; i < CAPACITY; i++) set_slots[SLOT_W'(i)] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_fill();
    test_random(265, 40, 0, 0);
    test_random(265, 30, 74, 0);
    test_random(265, 42, 0, 74);
    test_random(265, 28, 14, 14);

    in_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
